>>> hw/rtl/timed_event_queue_macros.svh
// ----------------------------------------------------------------------------
// Timed event queue assertion macros
// Shared concurrent checks, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH

// same-cycle implication
`define TEQ_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timed_event_queue: check failed");

// next-cycle implication
`define TEQ_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timed_event_queue: check failed");

`endif

>>> hw/rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// Timed event queue package
// Types, codes and helpers shared by the queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package teq_pkg;

   localparam int NUM_SLOTS_DEF = 32;
   localparam int REQ_W         = 56;
   localparam int RSP_W         = 56;
   localparam logic [31:0] PHASE_BITS = 32'hFF00_0000;
   localparam logic [31:0] ID_BITS    = 32'h0000_FFFF;

   typedef enum logic [3:0] {
      ACT_TICK       = 4'd0,
      ACT_SCHEDULE   = 4'd1,
      ACT_RESCHEDULE = 4'd2,
      ACT_REPEAT     = 4'd3,
      ACT_EXECUTE    = 4'd4,
      ACT_CANCEL     = 4'd5,
      ACT_CANCEL_GRP = 4'd6,
      ACT_DELAY_GRP  = 4'd7,
      ACT_DELAY_MAX  = 4'd8,
      ACT_PULL_BACK  = 4'd9,
      ACT_SET_PHASE  = 4'd10,
      ACT_ADD_PHASE  = 4'd11,
      ACT_REM_PHASE  = 4'd12,
      ACT_EVENT_TIME = 4'd13,
      ACT_TIME_UNTIL = 4'd14,
      ACT_RESET      = 4'd15
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_POST,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MD_INSERT,
      MD_EXEC,
      MD_CLEAR,
      MD_SELECT,
      MD_MOVE,
      MD_QUERY
   } mode_type;

   typedef struct packed {
      logic clear;
      logic eval;
      logic min_cand;
      logic free_cand;
   } scan_ctl_type;

   // group 1..8 -> bit 16..23
   function automatic logic [31:0] group_bit(input logic [3:0] grp);
      logic [31:0] b;
      b = '0;
      if (grp >= 4'd1 && grp <= 4'd8) begin
         b[5'(grp) + 5'd15] = 1'b1;
      end
      return b;
   endfunction

   // phase 1..8 -> bit 24..31
   function automatic logic [31:0] phase_bit(input logic [3:0] ph);
      logic [31:0] b;
      b = '0;
      if (ph >= 4'd1 && ph <= 4'd8) begin
         b[5'(ph) + 5'd23] = 1'b1;
      end
      return b;
   endfunction

   // phase 1..8 -> mask bit 0..7
   function automatic logic [7:0] phase_mask_bit(input logic [3:0] ph);
      logic [7:0] b;
      b = '0;
      if (ph >= 4'd1 && ph <= 4'd8) begin
         b[3'(ph - 4'd1)] = 1'b1;
      end
      return b;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/timed_event_queue.sv
// ----------------------------------------------------------------------------
// Timed event queue
// Table of pending timed events with a shared one-slot-a-cycle scan unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command item (action in req_tuser, arguments in
//   req_tdata); rsp_* returns exactly one result item per command.
//   One command is worked on at a time; req_tready is high only while idle.
//   Clock, phase and reset actions skip the scan and go to the output step.
//   A scan reads every slot through the slot RAMs' read port and the rank
//   unit, then decides in the post step: schedule, cancel and queries take
//   one scan. Execute takes one scan plus one more scan per dropped
//   out-of-phase event. Delay group and delay to max take one scan plus one
//   scan per moved entry, plus a final scan; delay group with a group
//   outside 1..8 takes no scan.
//   Reset empties the table, zeroes the clock and phase set; the insert
//   order and the last fired event are kept.
//   A stalled result waits in the output register; the next command is
//   still accepted and its result is held back until the register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "timed_event_queue_macros.svh"

module timed_event_queue #(
   parameter int NUM_SLOTS = teq_pkg::NUM_SLOTS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // event_id[15:0], amount[47:16], group[51:48], phase[55:52]
   input  wire logic [teq_pkg::REQ_W-1:0] req_tdata,
   // action[3:0]
   input  wire logic [3:0]                req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // fired_id[15:0], time_result[47:16], found[48], table_full[49],
   // in_phase[50], zero[55:51]
   output logic [teq_pkg::RSP_W-1:0]      rsp_tdata
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   teq_pkg::state_type  state_ff, state_in;
   teq_pkg::mode_type   mode_ff, mode_in;
   teq_pkg::action_type act_ff, act_in;

   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]     pipe_idx_ff, pipe_idx_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_SLOTS-1:0] sel_ff, sel_in;
   logic [31:0]          now_ff, now_in;
   logic [7:0]           mask_ff, mask_in;
   logic [31:0]          last_word_ff, last_word_in;
   logic [31:0]          counter_ff, counter_in;
   logic [31:0]          order_next_ff, order_next_in;
   logic [15:0]          id_ff, id_in;
   logic [31:0]          amt_ff, amt_in;
   logic [3:0]           grp_ff, grp_in;
   logic [3:0]           ph_ff, ph_in;
   logic [31:0]          limit_ff, limit_in;
   logic [15:0]          fired_ff, fired_in;
   logic [31:0]          tres_ff, tres_in;
   logic                 found_ff, found_in;
   logic                 full_ff, full_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [teq_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 we;
   logic [IDX_W-1:0]     waddr;
   logic [31:0]          wdue, wword, worder;
   logic [IDX_W-1:0]     raddr;
   logic [31:0]          rd_due, rd_word, rd_order;

   teq_pkg::scan_ctl_type scan_ctl;
   logic                 best_vld, free_vld;
   logic [IDX_W-1:0]     best_idx, free_idx;
   logic [31:0]          best_due, best_word;

   logic [31:0]          gbit;
   logic                 slot_v, id_hit, grp_hit, clear_hit, drop;
   logic                 in_phase;
   logic                 post_ins, post_move, post_fire;

   teq_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_due_ram (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wdue),
      .rd_addr(raddr), .rd_data(rd_due)
   );

   teq_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_word_ram (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wword),
      .rd_addr(raddr), .rd_data(rd_word)
   );

   teq_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_order_ram (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(worder),
      .rd_addr(raddr), .rd_data(rd_order)
   );

   teq_scan #(.NUM_SLOTS(NUM_SLOTS)) u_scan (
      .clock(clock), .reset(reset), .ctl(scan_ctl), .idx(pipe_idx_ff),
      .due(rd_due), .word(rd_word), .order(rd_order), .counter(counter_ff),
      .best_vld(best_vld), .best_idx(best_idx), .best_due(best_due),
      .best_word(best_word), .free_vld(free_vld), .free_idx(free_idx)
   );

   always_comb begin
      gbit     = teq_pkg::group_bit(grp_ff);
      slot_v   = valid_ff[pipe_idx_ff];
      id_hit   = (rd_word[15:0] == id_ff);
      grp_hit  = |(rd_word & gbit);
      drop     = (mask_ff != '0) && ((best_word & teq_pkg::PHASE_BITS) != '0) &&
                 ((best_word[31:24] & mask_ff) == '0);
      in_phase = (ph_ff == '0) || |(teq_pkg::phase_mask_bit(ph_ff) & mask_ff);

      clear_hit = 1'b0;
      if (act_ff == teq_pkg::ACT_CANCEL_GRP) begin
         clear_hit = slot_v && grp_hit;
      end else if (act_ff == teq_pkg::ACT_CANCEL || act_ff == teq_pkg::ACT_RESCHEDULE) begin
         clear_hit = slot_v && id_hit;
      end

      state_in      = state_ff;
      mode_in       = mode_ff;
      act_in        = act_ff;
      cnt_in        = cnt_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = pipe_idx_ff;
      valid_in      = valid_ff;
      sel_in        = sel_ff;
      now_in        = now_ff;
      mask_in       = mask_ff;
      last_word_in  = last_word_ff;
      counter_in    = counter_ff;
      order_next_in = order_next_ff;
      id_in         = id_ff;
      amt_in        = amt_ff;
      grp_in        = grp_ff;
      ph_in         = ph_ff;
      limit_in      = limit_ff;
      fired_in      = fired_ff;
      tres_in       = tres_ff;
      found_in      = found_ff;
      full_in       = full_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_data_in   = rsp_data_ff;
      raddr         = cnt_ff[IDX_W-1:0];
      we            = 1'b0;
      waddr         = best_idx;
      wdue          = best_due;
      wword         = best_word;
      worder        = order_next_ff;
      scan_ctl      = '0;
      req_tready    = (state_ff == teq_pkg::ST_IDLE);

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         teq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               act_in   = teq_pkg::action_type'(req_tuser);
               id_in    = req_tdata[15:0];
               amt_in   = req_tdata[47:16];
               grp_in   = req_tdata[51:48];
               ph_in    = req_tdata[55:52];
               state_in = teq_pkg::ST_START;
            end
         end
         teq_pkg::ST_START: begin
            fired_in       = '0;
            tres_in        = '0;
            found_in       = 1'b0;
            full_in        = 1'b0;
            cnt_in         = '0;
            scan_ctl.clear = 1'b1;
            state_in       = teq_pkg::ST_SCAN;
            unique case (act_ff) inside
               teq_pkg::ACT_TICK: begin
                  now_in   = now_ff + amt_ff;
                  state_in = teq_pkg::ST_OUT;
               end
               teq_pkg::ACT_PULL_BACK: begin
                  now_in   = (amt_ff < now_ff) ? (now_ff - amt_ff) : '0;
                  state_in = teq_pkg::ST_OUT;
               end
               teq_pkg::ACT_SET_PHASE: begin
                  if (ph_ff <= 4'd8) begin
                     mask_in = teq_pkg::phase_mask_bit(ph_ff);
                  end
                  state_in = teq_pkg::ST_OUT;
               end
               teq_pkg::ACT_ADD_PHASE: begin
                  mask_in  = mask_ff | teq_pkg::phase_mask_bit(ph_ff);
                  state_in = teq_pkg::ST_OUT;
               end
               teq_pkg::ACT_REM_PHASE: begin
                  mask_in  = mask_ff & ~teq_pkg::phase_mask_bit(ph_ff);
                  state_in = teq_pkg::ST_OUT;
               end
               teq_pkg::ACT_RESET: begin
                  valid_in = '0;
                  now_in   = '0;
                  mask_in  = '0;
                  state_in = teq_pkg::ST_OUT;
               end
               teq_pkg::ACT_SCHEDULE, teq_pkg::ACT_RESCHEDULE, teq_pkg::ACT_REPEAT: begin
                  mode_in = teq_pkg::MD_INSERT;
               end
               teq_pkg::ACT_EXECUTE: begin
                  mode_in = teq_pkg::MD_EXEC;
               end
               teq_pkg::ACT_CANCEL, teq_pkg::ACT_CANCEL_GRP: begin
                  mode_in = teq_pkg::MD_CLEAR;
               end
               teq_pkg::ACT_DELAY_GRP: begin
                  mode_in = teq_pkg::MD_SELECT;
                  if (gbit == '0) begin
                     state_in = teq_pkg::ST_OUT;
                  end
               end
               teq_pkg::ACT_DELAY_MAX: begin
                  mode_in  = teq_pkg::MD_SELECT;
                  limit_in = now_ff + amt_ff;
               end
               teq_pkg::ACT_EVENT_TIME, teq_pkg::ACT_TIME_UNTIL: begin
                  mode_in = teq_pkg::MD_QUERY;
               end
            endcase
         end
         teq_pkg::ST_SCAN: begin
            if (cnt_ff < CNT_W'(NUM_SLOTS)) begin
               pipe_vld_in = 1'b1;
               pipe_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in      = cnt_ff + CNT_W'(1);
            end else begin
               state_in = teq_pkg::ST_POST;
            end
            if (pipe_vld_ff) begin
               scan_ctl.eval = 1'b1;
               case (mode_ff)
                  teq_pkg::MD_INSERT: begin
                     scan_ctl.free_cand = !slot_v || clear_hit;
                     if (clear_hit) begin
                        valid_in[pipe_idx_ff] = 1'b0;
                     end
                  end
                  teq_pkg::MD_EXEC: begin
                     scan_ctl.min_cand = slot_v;
                  end
                  teq_pkg::MD_CLEAR: begin
                     if (clear_hit) begin
                        valid_in[pipe_idx_ff] = 1'b0;
                     end
                  end
                  teq_pkg::MD_SELECT: begin
                     if (act_ff == teq_pkg::ACT_DELAY_GRP) begin
                        sel_in[pipe_idx_ff] = slot_v && grp_hit;
                     end else begin
                        sel_in[pipe_idx_ff] = slot_v && (rd_due < limit_ff) &&
                                              ((grp_ff == '0) || grp_hit);
                     end
                  end
                  teq_pkg::MD_MOVE: begin
                     scan_ctl.min_cand = sel_ff[pipe_idx_ff];
                  end
                  teq_pkg::MD_QUERY: begin
                     scan_ctl.min_cand = slot_v && (id_hit ||
                        ((act_ff == teq_pkg::ACT_EVENT_TIME) && (id_ff == '0)));
                  end
                  default: begin
                     scan_ctl.eval = 1'b0;
                  end
               endcase
            end
         end
         teq_pkg::ST_POST: begin
            state_in = teq_pkg::ST_OUT;
            case (mode_ff)
               teq_pkg::MD_INSERT: begin
                  waddr = free_idx;
                  wdue  = now_ff + amt_ff;
                  wword = (act_ff == teq_pkg::ACT_REPEAT) ? last_word_ff :
                          ({16'd0, id_ff} | gbit | teq_pkg::phase_bit(ph_ff));
                  worder = counter_ff;
                  if (free_vld) begin
                     we                 = 1'b1;
                     valid_in[free_idx] = 1'b1;
                     counter_in         = counter_ff + 32'd1;
                  end else begin
                     full_in = 1'b1;
                  end
               end
               teq_pkg::MD_EXEC: begin
                  if (best_vld && (best_due <= now_ff)) begin
                     valid_in[best_idx] = 1'b0;
                     if (drop) begin
                        cnt_in         = '0;
                        scan_ctl.clear = 1'b1;
                        state_in       = teq_pkg::ST_SCAN;
                     end else begin
                        fired_in     = best_word[15:0];
                        last_word_in = best_word;
                        found_in     = 1'b1;
                     end
                  end
               end
               teq_pkg::MD_SELECT: begin
                  mode_in        = teq_pkg::MD_MOVE;
                  order_next_in  = counter_ff;
                  cnt_in         = '0;
                  scan_ctl.clear = 1'b1;
                  state_in       = teq_pkg::ST_SCAN;
               end
               teq_pkg::MD_MOVE: begin
                  if (best_vld) begin
                     we                = 1'b1;
                     wdue              = (act_ff == teq_pkg::ACT_DELAY_GRP) ?
                                         (best_due + amt_ff) : limit_ff;
                     sel_in[best_idx]  = 1'b0;
                     order_next_in     = order_next_ff + 32'd1;
                     cnt_in            = '0;
                     scan_ctl.clear    = 1'b1;
                     state_in          = teq_pkg::ST_SCAN;
                  end else begin
                     counter_in = order_next_ff;
                  end
               end
               teq_pkg::MD_QUERY: begin
                  found_in = best_vld;
                  if (act_ff == teq_pkg::ACT_TIME_UNTIL) begin
                     tres_in = best_vld ? (best_due - now_ff) : '1;
                  end else begin
                     tres_in = best_vld ? best_due : '0;
                  end
               end
               default: begin
               end
            endcase
         end
         teq_pkg::ST_OUT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {5'd0, in_phase, full_ff, found_ff, tres_ff, fired_ff};
               state_in    = teq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = teq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= teq_pkg::ST_IDLE;
         mode_ff      <= teq_pkg::MD_INSERT;
         cnt_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         valid_ff     <= '0;
         sel_ff       <= '0;
         now_ff       <= '0;
         mask_ff      <= '0;
         last_word_ff <= '0;
         counter_ff   <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         pipe_vld_ff  <= pipe_vld_in;
         valid_ff     <= valid_in;
         sel_ff       <= sel_in;
         now_ff       <= now_in;
         mask_ff      <= mask_in;
         last_word_ff <= last_word_in;
         counter_ff   <= counter_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      act_ff        <= act_in;
      pipe_idx_ff   <= pipe_idx_in;
      order_next_ff <= order_next_in;
      id_ff         <= id_in;
      amt_ff        <= amt_in;
      grp_ff        <= grp_in;
      ph_ff         <= ph_in;
      limit_ff      <= limit_in;
      fired_ff      <= fired_in;
      tres_ff       <= tres_in;
      found_ff      <= found_in;
      full_ff       <= full_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign post_ins  = (state_ff == teq_pkg::ST_POST) && (mode_ff == teq_pkg::MD_INSERT);
   assign post_move = (state_ff == teq_pkg::ST_POST) && (mode_ff == teq_pkg::MD_MOVE);
   assign post_fire = (state_ff == teq_pkg::ST_POST) && (mode_ff == teq_pkg::MD_EXEC) &&
                      best_vld && (best_due <= now_ff);

   `TEQ_ASSERT_IMP(a_sel_in_valid, 1'b1, (sel_ff & ~valid_ff) == '0)
   `TEQ_ASSERT_IMP(a_ins_free, post_ins && free_vld, !valid_ff[free_idx])
   `TEQ_ASSERT_IMP(a_move_sel, post_move && best_vld, sel_ff[best_idx])
   `TEQ_ASSERT_NXT(a_fire_clears, post_fire, !valid_ff[$past(best_idx)])

endmodule

`default_nettype wire

>>> hw/rtl/teq_ram.sv
// ----------------------------------------------------------------------------
// Timed event queue RAM
// Generic one-write one-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module teq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = teq_pkg::NUM_SLOTS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/teq_scan.sv
// ----------------------------------------------------------------------------
// Timed event queue scan unit
// Ranks one slot a cycle against the running best; tracks first free slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module teq_scan #(
   parameter int NUM_SLOTS = teq_pkg::NUM_SLOTS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire teq_pkg::scan_ctl_type        ctl,
   input  wire logic [$clog2(NUM_SLOTS)-1:0] idx,
   input  wire logic [31:0]                  due,
   input  wire logic [31:0]                  word,
   input  wire logic [31:0]                  order,
   input  wire logic [31:0]                  counter,
   output logic                              best_vld,
   output logic [$clog2(NUM_SLOTS)-1:0]      best_idx,
   output logic [31:0]                       best_due,
   output logic [31:0]                       best_word,
   output logic                              free_vld,
   output logic [$clog2(NUM_SLOTS)-1:0]      free_idx
);

   localparam int IDX_W = $clog2(NUM_SLOTS);

   logic             best_vld_ff, best_vld_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [31:0]      best_due_ff, best_due_in;
   logic [31:0]      best_age_ff, best_age_in;
   logic [31:0]      best_word_ff, best_word_in;
   logic             free_vld_ff, free_vld_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [31:0]      age;
   logic             better;

   always_comb begin
      age    = counter - order;
      better = !best_vld_ff || (due < best_due_ff) ||
               ((due == best_due_ff) && (age > best_age_ff));
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_due_in  = best_due_ff;
      best_age_in  = best_age_ff;
      best_word_in = best_word_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      if (ctl.clear) begin
         best_vld_in = 1'b0;
         free_vld_in = 1'b0;
      end else if (ctl.eval) begin
         if (ctl.min_cand && better) begin
            best_vld_in  = 1'b1;
            best_idx_in  = idx;
            best_due_in  = due;
            best_age_in  = age;
            best_word_in = word;
         end
         if (ctl.free_cand && !free_vld_ff) begin
            free_vld_in = 1'b1;
            free_idx_in = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_vld_ff <= 1'b0;
         free_vld_ff <= 1'b0;
      end else begin
         best_vld_ff <= best_vld_in;
         free_vld_ff <= free_vld_in;
      end
      best_idx_ff  <= best_idx_in;
      best_due_ff  <= best_due_in;
      best_age_ff  <= best_age_in;
      best_word_ff <= best_word_in;
      free_idx_ff  <= free_idx_in;
   end

   assign best_vld  = best_vld_ff;
   assign best_idx  = best_idx_ff;
   assign best_due  = best_due_ff;
   assign best_word = best_word_ff;
   assign free_vld  = free_vld_ff;
   assign free_idx  = free_idx_ff;

endmodule

`default_nettype wire
